/* rtl/dblbp_pkg.sv */
// Package with the item and result types of the box placer.
package dblbp_pkg;

   localparam int unsigned DimWidth   = 5;
   localparam int unsigned IdWidth    = 8;
   localparam int unsigned ValueWidth = 16;
   localparam int unsigned PosWidth   = 4;
   localparam int unsigned TotalWidth = 24;

   localparam logic [TotalWidth-1:0] TotalMax = {TotalWidth{1'b1}};

   // Request codes.
   localparam logic ReqPlace = 1'b0;
   localparam logic ReqClear = 1'b1;

   // Configuration register indexes.
   localparam logic [1:0] CsrWidth  = 2'd0;
   localparam logic [1:0] CsrHeight = 2'd1;
   localparam logic [1:0] CsrDepth  = 2'd2;

   typedef struct packed {
      logic                  req_type;
      logic [IdWidth-1:0]    item_id;
      logic [DimWidth-1:0]   item_width;
      logic [DimWidth-1:0]   item_height;
      logic [DimWidth-1:0]   item_depth;
      logic [ValueWidth-1:0] item_value;
   } req_type;

   typedef struct packed {
      logic                  placed;
      logic [IdWidth-1:0]    echo_id;
      logic [PosWidth-1:0]   pos_x;
      logic [PosWidth-1:0]   pos_y;
      logic [PosWidth-1:0]   pos_z;
      logic [TotalWidth-1:0] total_value;
   } rsp_type;

endpackage

/* rtl/dblbp_ram.sv */
// Generic single-port-write, single-read RAM with a registered read.
module dblbp_ram #(
   parameter int unsigned WIDTH = 1,
   parameter int unsigned DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

/* rtl/deepest_bottom_left_box_placer_core.sv */
// Top level of the deepest-bottom-left box placer over a 3D occupancy grid.
// A place item passes a size check, probes each cell of an origin's region through the
// registered grid read (an origin is dropped at its first occupied cell), fills the free
// region and posts the result, so the worst case grows with origins times box volume.
// A clear item posts its result first and then sweeps all MAX_DEPTH*MAX_HEIGHT*MAX_WIDTH
// cells of the grid one cell per cycle, as after the synchronous reset.
// One item at a time: req_ready is high only when idle; a finished item waits for rsp_free.
module deepest_bottom_left_box_placer_core
   import dblbp_pkg::*;
#(
   parameter int unsigned MAX_WIDTH  = 16,
   parameter int unsigned MAX_HEIGHT = 16,
   parameter int unsigned MAX_DEPTH  = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_type             rsp_data,
   input  logic                csr_write,
   input  logic [1:0]          csr_index,
   input  logic [DimWidth-1:0] csr_data
);
   localparam int unsigned XW    = $clog2(MAX_WIDTH + 1);
   localparam int unsigned YW    = $clog2(MAX_HEIGHT + 1);
   localparam int unsigned ZW    = $clog2(MAX_DEPTH + 1);
   localparam int unsigned Cells = MAX_WIDTH * MAX_HEIGHT * MAX_DEPTH;
   localparam int unsigned AW    = (Cells > 1) ? $clog2(Cells) : 1;
   localparam int unsigned CW    = $clog2(Cells + 1);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_PROBE, S_WAIT, S_CHECK, S_FILL, S_DONE
   } state_type;

   state_type state_ff;
   logic [DimWidth-1:0] cfg_w_ff, cfg_h_ff, cfg_d_ff;
   req_type req_ff;
   logic [XW-1:0] cw_ff, ox_ff, cx_ff, lx_ff;
   logic [YW-1:0] ch_ff, oy_ff, cy_ff, ly_ff;
   logic [ZW-1:0] cd_ff, oz_ff, cz_ff, lz_ff;
   logic [CW-1:0] clr_ff;
   logic [TotalWidth-1:0] total_ff;
   logic found_ff;
   logic rsp_valid_ff;
   rsp_type rsp_ff;

   // Current cell address, and RAM wiring.
   logic [AW-1:0] cell_addr;
   logic wr_en;
   logic [AW-1:0] wr_addr;
   logic wr_data;
   logic rd_data;

   // The address is (z*H + y)*W + x, formed from constants and narrow counters.
   assign cell_addr = AW'((32'(cz_ff) * MAX_HEIGHT + 32'(cy_ff)) * MAX_WIDTH + 32'(cx_ff));
   assign wr_en   = (state_ff == S_CLEAR) || (state_ff == S_FILL);
   assign wr_addr = (state_ff == S_CLEAR) ? AW'(clr_ff) : cell_addr;
   assign wr_data = (state_ff == S_FILL);

   dblbp_ram #(.WIDTH(1), .DEPTH(Cells)) u_grid (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(cell_addr),
      .rd_data(rd_data)
   );

   // Container sizes clamped to the grid.
   function automatic logic [6:0] clamp(input logic [DimWidth-1:0] v, input int unsigned lim);
      logic [6:0] r;
      r = (32'(v) > lim) ? 7'(lim) : 7'(v);
      return r;
   endfunction

   // Derived values for the scan.
   logic last_cx, last_cy, last_cz, last_ox, last_oy, last_oz;
   logic [TotalWidth:0] sum;
   logic rsp_free;
   assign last_cx = (cx_ff == XW'(32'(ox_ff) + 32'(req_ff.item_width) - 1));
   assign last_cy = (cy_ff == YW'(32'(oy_ff) + 32'(req_ff.item_height) - 1));
   assign last_cz = (cz_ff == ZW'(32'(oz_ff) + 32'(req_ff.item_depth) - 1));
   assign last_ox = (ox_ff == lx_ff);
   assign last_oy = (oy_ff == ly_ff);
   assign last_oz = (oz_ff == lz_ff);
   assign sum = {1'b0, total_ff} + (TotalWidth + 1)'(req_ff.item_value);
   // The output register can take a new result when empty or being emptied.
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         cfg_w_ff     <= DimWidth'(16);
         cfg_h_ff     <= DimWidth'(16);
         cfg_d_ff     <= DimWidth'(16);
         total_ff     <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CsrWidth:  cfg_w_ff <= csr_data;
               CsrHeight: cfg_h_ff <= csr_data;
               CsrDepth:  cfg_d_ff <= csr_data;
               default: ;
            endcase
         end
         if (state_ff == S_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               if (clr_ff == CW'(Cells - 1)) begin
                  state_ff <= S_IDLE;
               end
               clr_ff <= clr_ff + 1'b1;
            end
            S_IDLE: begin
               if (req_valid) begin
                  req_ff   <= req_data;
                  found_ff <= 1'b0;
                  cw_ff <= XW'(clamp(cfg_w_ff, MAX_WIDTH));
                  ch_ff <= YW'(clamp(cfg_h_ff, MAX_HEIGHT));
                  cd_ff <= ZW'(clamp(cfg_d_ff, MAX_DEPTH));
                  ox_ff <= '0; oy_ff <= '0; oz_ff <= '0;
                  cx_ff <= '0; cy_ff <= '0; cz_ff <= '0;
                  if (req_data.req_type == ReqClear) begin
                     // The result goes out first; the sweep follows it.
                     total_ff <= '0;
                     clr_ff   <= '0;
                     state_ff <= S_DONE;
                  end else begin
                     state_ff <= S_CHECK;
                  end
               end
            end
            S_CHECK: begin
               // Reject degenerate or oversize boxes; else set the scan limits.
               if (req_ff.item_width == '0 || req_ff.item_height == '0 ||
                   req_ff.item_depth == '0 ||
                   32'(req_ff.item_width) > 32'(cw_ff) ||
                   32'(req_ff.item_height) > 32'(ch_ff) ||
                   32'(req_ff.item_depth) > 32'(cd_ff)) begin
                  state_ff <= S_DONE;
               end else begin
                  lx_ff <= XW'(32'(cw_ff) - 32'(req_ff.item_width));
                  ly_ff <= YW'(32'(ch_ff) - 32'(req_ff.item_height));
                  lz_ff <= ZW'(32'(cd_ff) - 32'(req_ff.item_depth));
                  state_ff <= S_PROBE;
               end
            end
            S_PROBE: begin
               state_ff <= S_WAIT;
            end
            S_WAIT: begin
               if (rd_data) begin
                  // Occupied: move on to the next origin.
                  if (last_ox && last_oy && last_oz) begin
                     state_ff <= S_DONE;
                  end else begin
                     if (!last_ox) begin
                        ox_ff <= ox_ff + 1'b1;
                        cx_ff <= ox_ff + 1'b1; cy_ff <= oy_ff; cz_ff <= oz_ff;
                     end else if (!last_oy) begin
                        ox_ff <= '0; oy_ff <= oy_ff + 1'b1;
                        cx_ff <= '0; cy_ff <= oy_ff + 1'b1; cz_ff <= oz_ff;
                     end else begin
                        ox_ff <= '0; oy_ff <= '0; oz_ff <= oz_ff + 1'b1;
                        cx_ff <= '0; cy_ff <= '0; cz_ff <= oz_ff + 1'b1;
                     end
                     state_ff <= S_PROBE;
                  end
               end else if (last_cx && last_cy && last_cz) begin
                  // Region free: restart at its first cell and fill.
                  cx_ff <= ox_ff; cy_ff <= oy_ff; cz_ff <= oz_ff;
                  state_ff <= S_FILL;
               end else begin
                  if (!last_cx) begin
                     cx_ff <= cx_ff + 1'b1;
                  end else if (!last_cy) begin
                     cx_ff <= ox_ff; cy_ff <= cy_ff + 1'b1;
                  end else begin
                     cx_ff <= ox_ff; cy_ff <= oy_ff; cz_ff <= cz_ff + 1'b1;
                  end
                  state_ff <= S_PROBE;
               end
            end
            S_FILL: begin
               if (last_cx && last_cy && last_cz) begin
                  found_ff <= 1'b1;
                  total_ff <= sum[TotalWidth] ? TotalMax : sum[TotalWidth-1:0];
                  state_ff <= S_DONE;
               end else if (!last_cx) begin
                  cx_ff <= cx_ff + 1'b1;
               end else if (!last_cy) begin
                  cx_ff <= ox_ff; cy_ff <= cy_ff + 1'b1;
               end else begin
                  cx_ff <= ox_ff; cy_ff <= oy_ff; cz_ff <= cz_ff + 1'b1;
               end
            end
            S_DONE: begin
               // Hold the finished item until the output register is free.
               if (rsp_free) begin
                  rsp_ff.placed      <= found_ff;
                  rsp_ff.echo_id     <= req_ff.item_id;
                  rsp_ff.pos_x       <= found_ff ? PosWidth'(ox_ff) : '0;
                  rsp_ff.pos_y       <= found_ff ? PosWidth'(oy_ff) : '0;
                  rsp_ff.pos_z       <= found_ff ? PosWidth'(oz_ff) : '0;
                  rsp_ff.total_value <= total_ff;
                  state_ff <= (req_ff.req_type == ReqClear) ? S_CLEAR : S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   // A waiting result stays valid and unchanged until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("result dropped or changed while waiting");
   // The grid is only written during a clear sweep or a fill.
   a_write_states: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_CLEAR || state_ff == S_FILL))
      else $error("grid written outside clear or fill");
   // A result for a box that was not placed carries the zero origin.
   a_unplaced_origin: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.placed) |->
         (rsp_data.pos_x == '0 && rsp_data.pos_y == '0 && rsp_data.pos_z == '0))
      else $error("origin not zero on a result that was not placed");
   // The total never decreases except on a clear.
   a_total_mono: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE && state_ff != S_CLEAR) |=> (total_ff >= $past(total_ff)))
      else $error("total decreased");
`endif
endmodule
